// File: rtl/value_keyed_linked_list_core_defines.svh
// Assertion macros shared by the linked list RTL.
`ifndef VALUE_KEYED_LINKED_LIST_CORE_DEFINES_SVH
`define VALUE_KEYED_LINKED_LIST_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define VKLL_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define VKLL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VKLL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vkll_pkg.sv
// Types and constants for the value keyed linked list core.
package vkll_pkg;

    localparam int NODES_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FUNC_W    = 3;
    localparam int IN_VAL_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;

    localparam int S_TDATA_W = 2 * IN_VAL_W;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = STATUS_W + 1;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - COUNT_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_HEAD   = 3'd1,
        FN_TAIL   = 3'd2,
        FN_FIND   = 3'd3,
        FN_MODIFY = 3'd4,
        FN_DELETE = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_A,
        S_INS_B,
        S_WALK,
        S_UPD,
        S_RESP
    } state_t;

endpackage

// File: rtl/vkll_ram.sv
// Generic single write port RAM with registered read.
module vkll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/value_keyed_linked_list_core.sv
// Top level of the value keyed doubly linked list core.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tuser: func; tdata: key_value, new_value
//  m_*      | out | m_tvalid/m_tready | tuser: status, found; tdata: position, count
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Clear, unused codes, insert into a full store and search of an empty list go straight
// to the response. Insert scans the free map for the lowest free slot (one slot a cycle),
// then writes the new node and links its neighbor. Find walks from the head to a match
// or the last entry; modify and delete add an update step for the link and value writes.
// The three node stores come out of reset undefined; only linked entries are read.
// A result waits in the output register while m_tready is low; the next item is
// taken meanwhile and finishes once the register frees up.
`include "value_keyed_linked_list_core_defines.svh"

module value_keyed_linked_list_core
    import vkll_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] key_value, [63:32] new_value
    input  logic [S_TUSER_W-1:0] s_tuser,  // [2:0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [3:0] position, [8:4] entry_count, zero pad
    output logic [M_TUSER_W-1:0] m_tuser   // [1:0] status, [2] found
);

    localparam int SLOT_BITS = $clog2(NODES);
    localparam int CNT_BITS  = $clog2(NODES + 1);
    localparam logic [SLOT_BITS:0]  NODE_LIMIT = (SLOT_BITS + 1)'(NODES);
    localparam logic [CNT_BITS-1:0] NODE_CNT   = CNT_BITS'(NODES);

    typedef logic [SLOT_BITS-1:0] slot_t;

    // links are always written with valid slots; this keeps stray values in range
    function automatic slot_t slot_ok(input slot_t s);
        return ({1'b0, s} < NODE_LIMIT) ? s : '0;
    endfunction

    // control state
    state_t              state_reg, state_next;
    slot_t               head_reg, head_next;
    slot_t               tail_reg, tail_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [NODES-1:0]    free_reg, free_next;
    logic                out_valid_reg, out_valid_next;

    // per-item working registers
    func_t               func_reg, func_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [VALUE_BITS-1:0] newv_reg, newv_next;
    slot_t               idx_reg, idx_next;     // walk position, or slot scan counter
    slot_t               cur_reg, cur_next;     // slot under the walk
    slot_t               nx_reg, nx_next;
    slot_t               pv_reg, pv_next;
    status_t             res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    slot_t               res_pos_reg, res_pos_next;

    // output register
    status_t             out_status_reg, out_status_next;
    logic                out_found_reg, out_found_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // node stores
    logic                  val_we, nxt_we, prv_we;
    slot_t                 val_waddr, nxt_waddr, prv_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    slot_t                 nxt_wdata, prv_wdata;
    slot_t                 rd_addr;
    logic [VALUE_BITS-1:0] val_rdata;
    slot_t                 nxt_rdata, prv_rdata;

    logic  accept;
    func_t acc_func;
    logic  match;
    logic  walk_last;
    logic  resp_load;
    logic  is_head, is_tail;

    assign accept    = s_tvalid && s_tready;
    assign acc_func  = func_t'(s_tuser[FUNC_W-1:0]);
    assign match     = (val_rdata == key_reg);
    assign walk_last = (CNT_BITS'(idx_reg) + CNT_BITS'(1)) >= count_reg;
    assign resp_load = (state_reg == S_RESP) && (!out_valid_reg || m_tready);
    assign is_head   = (cur_reg == head_reg);
    assign is_tail   = (cur_reg == tail_reg);

    vkll_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    vkll_ram #(.WIDTH(SLOT_BITS), .DEPTH(NODES)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    vkll_ram #(.WIDTH(SLOT_BITS), .DEPTH(NODES)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (acc_func) inside
                        FN_HEAD, FN_TAIL:
                            state_next = (count_reg >= NODE_CNT) ? S_RESP : S_SCAN;
                        FN_FIND, FN_MODIFY, FN_DELETE:
                            state_next = (count_reg == '0) ? S_RESP : S_WALK;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (free_reg[idx_reg])
                begin
                    state_next = S_INS_A;
                end
            end
            S_INS_A:
                state_next = S_INS_B;
            S_INS_B:
                state_next = S_RESP;
            S_WALK:
            begin
                if (match)
                begin
                    state_next = (func_reg == FN_FIND) ? S_RESP : S_UPD;
                end
                else if (walk_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_UPD:
                state_next = S_RESP;
            S_RESP:
            begin
                if (resp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        newv_next       = newv_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        nx_next         = nx_reg;
        pv_next         = pv_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        val_we    = 1'b0;
        val_waddr = cur_reg;
        val_wdata = newv_reg;
        nxt_we    = 1'b0;
        nxt_waddr = pv_reg;
        nxt_wdata = nx_reg;
        prv_we    = 1'b0;
        prv_waddr = nx_reg;
        prv_wdata = pv_reg;
        rd_addr   = slot_ok(head_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = acc_func;
                    key_next        = VALUE_BITS'($signed(s_tdata[IN_VAL_W-1:0]));
                    newv_next       = VALUE_BITS'($signed(s_tdata[S_TDATA_W-1:IN_VAL_W]));
                    idx_next        = '0;
                    cur_next        = slot_ok(head_reg);
                    res_status_next = STAT_DONE;
                    res_found_next  = 1'b0;
                    res_pos_next    = '0;
                    unique case (acc_func) inside
                        FN_CLEAR:
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                            free_next  = '1;
                        end
                        FN_HEAD, FN_TAIL:
                        begin
                            if (count_reg >= NODE_CNT)
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        FN_FIND, FN_MODIFY, FN_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_NOTFOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!free_reg[idx_reg])
                begin
                    idx_next = idx_reg + slot_t'(1);
                end
            end
            S_INS_A:
            begin
                // new node: value plus its own links
                val_we    = 1'b1;
                val_waddr = idx_reg;
                val_wdata = key_reg;
                nxt_we    = 1'b1;
                nxt_waddr = idx_reg;
                prv_we    = 1'b1;
                prv_waddr = idx_reg;
                if (count_reg == '0)
                begin
                    nxt_wdata = idx_reg;
                    prv_wdata = idx_reg;
                end
                else if (func_reg == FN_HEAD)
                begin
                    nxt_wdata = head_reg;
                    prv_wdata = idx_reg;
                end
                else
                begin
                    nxt_wdata = idx_reg;
                    prv_wdata = tail_reg;
                end
            end
            S_INS_B:
            begin
                // hook the neighbor to the new node
                if (count_reg == '0)
                begin
                    head_next = idx_reg;
                    tail_next = idx_reg;
                end
                else if (func_reg == FN_HEAD)
                begin
                    prv_we    = 1'b1;
                    prv_waddr = slot_ok(head_reg);
                    prv_wdata = idx_reg;
                    head_next = idx_reg;
                end
                else
                begin
                    nxt_we    = 1'b1;
                    nxt_waddr = slot_ok(tail_reg);
                    nxt_wdata = idx_reg;
                    tail_next = idx_reg;
                end
                free_next[idx_reg] = 1'b0;
                count_next         = count_reg + CNT_BITS'(1);
            end
            S_WALK:
            begin
                // data of cur_reg is on the read ports; fetch its successor now
                rd_addr = slot_ok(nxt_rdata);
                if (match)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = idx_reg;
                    nx_next        = slot_ok(nxt_rdata);
                    pv_next        = slot_ok(prv_rdata);
                end
                else if (walk_last)
                begin
                    res_status_next = STAT_NOTFOUND;
                end
                else
                begin
                    cur_next = slot_ok(nxt_rdata);
                    idx_next = idx_reg + slot_t'(1);
                end
            end
            S_UPD:
            begin
                if (func_reg == FN_MODIFY)
                begin
                    val_we = 1'b1;
                end
                else
                begin
                    // unlink; a new head keeps its stale back link
                    if (is_head && is_tail)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (is_head)
                    begin
                        head_next = nx_reg;
                    end
                    else if (is_tail)
                    begin
                        tail_next = pv_reg;
                        nxt_we    = 1'b1;
                        nxt_wdata = pv_reg;
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        prv_we = 1'b1;
                    end
                    free_next[cur_reg] = 1'b1;
                    count_next         = count_reg - CNT_BITS'(1);
                end
            end
            S_RESP:
            begin
                if (resp_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_pos_next    = POS_W'(res_pos_reg);
                    out_count_next  = COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            free_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        newv_reg       <= newv_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        nx_reg         <= nx_next;
        pv_reg         <= pv_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_count_reg, out_pos_reg};
    assign m_tuser  = {out_found_reg, out_status_reg};

    `VKLL_ASSERT_HOLD(a_count_bound, count_reg <= NODE_CNT, "entry count above store size")
    `VKLL_ASSERT_IMP(a_ins_slot_free, state_reg == S_INS_B, free_reg[idx_reg],
        "insert claims a slot that is in use")
    `VKLL_ASSERT_IMP(a_walk_in_list, state_reg == S_WALK, CNT_BITS'(idx_reg) < count_reg,
        "walk ran past the list end")
    `VKLL_ASSERT_NXT(a_resp_handoff, resp_load, m_tvalid && (state_reg == S_IDLE),
        "result not handed to the output register")
    `VKLL_ASSERT_IMP(a_found_done, out_valid_reg && out_found_reg,
        out_status_reg == STAT_DONE, "found result with a failure status")

endmodule
